[hdl/geyer_saturation_intensity_unit_macros.svh]
// Assertion macros of the saturation intensity unit, used by the gsi_ctrl module.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef GEYER_SATURATION_INTENSITY_UNIT_MACROS_SVH
`define GEYER_SATURATION_INTENSITY_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsi assertion failed");
`define GSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsi assertion failed");
`else
`define GSI_ASSERT_IMP(lbl, ante, cons)
`define GSI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hdl/gsi_pkg.sv]
// Shared types, constants and functions of the saturation intensity unit.
// Used by gsi_ctrl, gsi_dp and the top level (not by gsi_ram); depends on nothing.
`default_nettype none
package gsi_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = 10;
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int ONE_Q      = 256;
  localparam int Q_W        = 19;
  localparam int W_W        = 20;
  localparam int LG_W       = 24;
  localparam int RSQ_W      = 33;
  localparam int LI_W       = 35;
  localparam int ENTRY_W    = CNT_W + 2 * COORD_W;
  localparam int PADDR_W    = 6;
  localparam int PDATA_W    = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    KIND_BIRTH = 2'd0,
    KIND_DEATH = 2'd1,
    KIND_SHIFT = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  localparam logic CMD_EVAL   = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  localparam logic [2:0] REG_LOG_GAMMA  = 3'd0;
  localparam logic [2:0] REG_RADIUS_SQ  = 3'd1;
  localparam logic [2:0] REG_SATURATION = 3'd2;
  localparam logic [2:0] REG_HARD_CORE  = 3'd3;
  localparam logic [2:0] REG_PERIODIC   = 3'd4;
  localparam logic [2:0] REG_PERIOD_X   = 3'd5;
  localparam logic [2:0] REG_PERIOD_Y   = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LATCH,
    S_WALK,
    S_DRAIN,
    S_FINAL,
    S_MULT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic signed [LG_W-1:0] log_gamma;
    logic [RSQ_W-1:0]       radius_sq;
    logic [Q_W-1:0]         saturation;
    logic                   hard_core;
    logic                   periodic;
    logic [COORD_W-1:0]     period_x;
    logic [COORD_W-1:0]     period_y;
  } cfg_t;

  typedef struct packed {
    logic              ld_in;
    logic              rd_en;
    logic              walk;
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_old;
    logic              fin;
    logic [ADDR_W-1:0] fin_addr;
    logic              mul;
    logic              out_load;
    status_t           err;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } sts_t;

  // Axis distance with optional wraparound over the window period.
  function automatic logic [COORD_W-1:0] fold_dist(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [COORD_W-1:0] per,
                                                   input logic               wrap);
    logic [COORD_W-1:0]      d0;
    logic signed [COORD_W+1:0] alt;
    logic signed [COORD_W+1:0] r;
    d0  = (a >= b) ? (a - b) : (b - a);
    alt = $signed({2'b00, per}) - $signed({2'b00, d0});
    r   = $signed({2'b00, d0});
    if (wrap && (alt < r)) begin
      r = alt;
    end
    if (r < 0) begin
      r = -r;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/gsi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/gsi_ctrl.sv]
// Sequencer of the saturation intensity unit: item checks, store walk, point count.
// Depends on gsi_pkg and the assertion macro header.
`default_nettype none
`include "geyer_saturation_intensity_unit_macros.svh"
module gsi_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic                       in_command,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [gsi_pkg::ADDR_W-1:0] in_index,
  input  wire gsi_pkg::sts_t              sts,
  output gsi_pkg::cmd_t                   cmd
);
  import gsi_pkg::*;

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              command_r, command_nxt;
  kind_t             kind_r, kind_nxt;
  logic [ADDR_W-1:0] ix_r, ix_nxt;
  status_t           err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      j_r       <= '0;
      count_r   <= '0;
      command_r <= CMD_EVAL;
      kind_r    <= KIND_BIRTH;
      ix_r      <= '0;
      err_r     <= STAT_OK;
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      count_r   <= count_nxt;
      command_r <= command_nxt;
      kind_r    <= kind_nxt;
      ix_r      <= ix_nxt;
      err_r     <= err_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    count_nxt   = count_r;
    command_nxt = command_r;
    kind_nxt    = kind_r;
    ix_nxt      = ix_r;
    err_nxt     = err_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.err     = err_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_in   = 1'b1;
          command_nxt = in_command;
          kind_nxt    = kind_t'(in_kind);
          ix_nxt      = in_index;
          if ((kind_t'(in_kind) == KIND_BAD) ||
              ((kind_t'(in_kind) != KIND_BIRTH) && ({1'b0, in_index} >= count_r))) begin
            err_nxt   = STAT_BAD;
            state_nxt = S_DONE;
          end else if ((kind_t'(in_kind) == KIND_BIRTH) && (count_r >= CNT_MAX)) begin
            err_nxt   = STAT_FULL;
            state_nxt = S_DONE;
          end else begin
            err_nxt   = STAT_OK;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ix_r;
        state_nxt   = S_LATCH;
      end
      S_LATCH: begin
        cmd.ld_old = 1'b1;
        j_nxt      = '0;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        if (j_r < count_r) begin
          cmd.rd_en   = 1'b1;
          cmd.walk    = 1'b1;
          cmd.rd_addr = j_r[ADDR_W-1:0];
          j_nxt       = j_r + 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.fin      = 1'b1;
        cmd.fin_addr = (kind_r == KIND_BIRTH) ? count_r[ADDR_W-1:0] : ix_r;
        if (command_r == CMD_COMMIT) begin
          if (kind_r == KIND_BIRTH) begin
            count_nxt = count_r + 1'b1;
          end else if (kind_r == KIND_DEATH) begin
            count_nxt = count_r - 1'b1;
          end
        end
        state_nxt = S_MULT;
      end
      S_MULT: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `GSI_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_MAX)
  `GSI_ASSERT_IMP(a_walk_bound, cmd.walk, j_r < count_r)
  `GSI_ASSERT_IMP(a_load_free, cmd.out_load, !sts.out_full)
  `GSI_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)

endmodule
`default_nettype wire

[hdl/gsi_dp.sv]
// Datapath of the saturation intensity unit: point store, closeness pipeline,
// weight accumulation, count updates and the result register. Depends on gsi_pkg, gsi_ram.
`default_nettype none
module gsi_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gsi_pkg::cfg_t               cfg,
  input  wire gsi_pkg::cmd_t               cmd,
  output gsi_pkg::sts_t                    sts,
  input  wire logic                        in_command,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [gsi_pkg::ADDR_W-1:0]  in_index,
  input  wire logic [gsi_pkg::COORD_W-1:0] in_x,
  input  wire logic [gsi_pkg::COORD_W-1:0] in_y,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [gsi_pkg::CNT_W-1:0]        out_neighbours,
  output logic [gsi_pkg::W_W-1:0]          out_log_weight,
  output logic signed [gsi_pkg::LI_W-1:0]  out_log_intensity,
  output logic                             out_intensity_zero,
  output gsi_pkg::status_t                 out_status
);
  import gsi_pkg::*;

  // Item registers.
  logic               command_r;
  kind_t              kind_r;
  logic [ADDR_W-1:0]  ix_r;
  logic [COORD_W-1:0] u_r, v_r;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [CNT_W-1:0]   ocnt_r;

  // Accumulators and final result.
  logic [W_W-1:0]          w_r;
  logic [CNT_W-1:0]        tally_r;
  logic [CNT_W-1:0]        tee_r;
  logic [CNT_W-1:0]        tee;
  logic [Q_W-1:0]          t_q;
  logic signed [LI_W-1:0]  li_r;
  logic signed [LG_W+W_W:0] prod;

  // Store.
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  gsi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  logic [COORD_W-1:0] rd_x, rd_y;
  logic [CNT_W-1:0]   rd_cnt;
  assign rd_x   = rd_data[COORD_W-1:0];
  assign rd_y   = rd_data[2*COORD_W-1:COORD_W];
  assign rd_cnt = rd_data[ENTRY_W-1:2*COORD_W];

  logic [COORD_W-1:0] px, py;
  assign px = (kind_r == KIND_DEATH) ? ox_r : u_r;
  assign py = (kind_r == KIND_DEATH) ? oy_r : v_r;

  // Pipeline registers.
  logic               s0_v_r;
  logic [ADDR_W-1:0]  s0_j_r;
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic [ADDR_W-1:0]  s1_j_r, s2_j_r, s3_j_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic [CNT_W-1:0]   s1_c_r, s2_c_r, s3_c_r;
  logic [COORD_W-1:0] s1_dpx_r, s1_dpy_r, s1_dox_r, s1_doy_r;
  logic [2*COORD_W-1:0] s2_spx_r, s2_spy_r, s2_sox_r, s2_soy_r;
  logic               s3_np_r, s3_no_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= cmd.walk;
      s1_v_r <= s0_v_r && !((kind_r != KIND_BIRTH) && (s0_j_r == ix_r));
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_j_r   <= cmd.rd_addr;
    s1_j_r   <= s0_j_r;
    s1_x_r   <= rd_x;
    s1_y_r   <= rd_y;
    s1_c_r   <= rd_cnt;
    s1_dpx_r <= fold_dist(px, rd_x, cfg.period_x, cfg.periodic);
    s1_dpy_r <= fold_dist(py, rd_y, cfg.period_y, cfg.periodic);
    s1_dox_r <= fold_dist(ox_r, rd_x, cfg.period_x, cfg.periodic);
    s1_doy_r <= fold_dist(oy_r, rd_y, cfg.period_y, cfg.periodic);
    s2_j_r   <= s1_j_r;
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    s2_c_r   <= s1_c_r;
    s2_spx_r <= s1_dpx_r * s1_dpx_r;
    s2_spy_r <= s1_dpy_r * s1_dpy_r;
    s2_sox_r <= s1_dox_r * s1_dox_r;
    s2_soy_r <= s1_doy_r * s1_doy_r;
    s3_j_r   <= s2_j_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_c_r   <= s2_c_r;
    s3_np_r  <= ({1'b0, s2_spx_r} + {1'b0, s2_spy_r}) < cfg.radius_sq;
    s3_no_r  <= ({1'b0, s2_sox_r} + {1'b0, s2_soy_r}) < cfg.radius_sq;
  end

  assign sts.pipe_busy = s0_v_r | s1_v_r | s2_v_r | s3_v_r;

  // Per-point weight term and count update.
  logic [Q_W-1:0]          a_q;
  logic signed [Q_W+1:0]   g;
  logic [FRAC_W:0]         term;
  logic                    bias;
  logic [CNT_W-1:0]        cnt_inc, cnt_dec, cnt_new;

  always_comb begin
    a_q  = {s3_c_r, {FRAC_W{1'b0}}};
    bias = (kind_r == KIND_DEATH) || ((kind_r == KIND_SHIFT) && s3_no_r);
    g    = $signed({2'b00, cfg.saturation}) - $signed({2'b00, a_q});
    if (bias) begin
      g = g + (Q_W+2)'(ONE_Q);
    end
    if (g < 0) begin
      term = '0;
    end else if (g > (Q_W+2)'(ONE_Q)) begin
      term = (FRAC_W+1)'(ONE_Q);
    end else begin
      term = g[FRAC_W:0];
    end
    cnt_inc = (s3_c_r < CNT_MAX) ? (s3_c_r + 1'b1) : s3_c_r;
    cnt_dec = (s3_c_r != '0) ? (s3_c_r - 1'b1) : s3_c_r;
    cnt_new = s3_c_r;
    case (kind_r)
      KIND_BIRTH: if (s3_np_r) cnt_new = cnt_inc;
      KIND_DEATH: if (s3_np_r) cnt_new = cnt_dec;
      default: begin
        if (s3_np_r && !s3_no_r) begin
          cnt_new = cnt_inc;
        end else if (!s3_np_r && s3_no_r) begin
          cnt_new = cnt_dec;
        end
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s3_j_r;
    wr_data = {cnt_new, s3_y_r, s3_x_r};
    if (cmd.fin) begin
      wr_en   = (command_r == CMD_COMMIT) && (kind_r != KIND_DEATH);
      wr_addr = cmd.fin_addr;
      wr_data = {tally_r, v_r, u_r};
    end else if (s3_v_r && (command_r == CMD_COMMIT)) begin
      wr_en = 1'b1;
      if ((kind_r == KIND_DEATH) && (s3_j_r > ix_r)) begin
        wr_addr = s3_j_r - 1'b1;
      end
    end
  end

  assign tee  = (kind_r == KIND_DEATH) ? ocnt_r : tally_r;
  assign t_q  = {tee, {FRAC_W{1'b0}}};
  assign prod = cfg.log_gamma * $signed({1'b0, w_r});

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      command_r <= in_command;
      kind_r    <= kind_t'(in_kind);
      ix_r      <= in_index;
      u_r       <= in_x;
      v_r       <= in_y;
      w_r       <= '0;
      tally_r   <= '0;
    end else if (s3_v_r && s3_np_r) begin
      w_r     <= w_r + W_W'(term);
      if (kind_r != KIND_DEATH) begin
        tally_r <= tally_r + 1'b1;
      end
    end else if (cmd.fin) begin
      w_r   <= w_r + W_W'((t_q < cfg.saturation) ? t_q : cfg.saturation);
      tee_r <= tee;
    end
    if (cmd.ld_old) begin
      ox_r   <= rd_x;
      oy_r   <= rd_y;
      ocnt_r <= rd_cnt;
    end
    if (cmd.mul) begin
      li_r <= cfg.hard_core ? '0 : prod[LI_W+FRAC_W-1:FRAC_W];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status         <= cmd.err;
      out_neighbours     <= '0;
      out_log_weight     <= '0;
      out_log_intensity  <= '0;
      out_intensity_zero <= 1'b0;
      if (cmd.err == STAT_OK) begin
        out_neighbours <= tee_r;
        if (command_r == CMD_EVAL) begin
          out_log_weight     <= w_r;
          out_log_intensity  <= li_r;
          out_intensity_zero <= cfg.hard_core && (tee_r != '0);
        end
      end
    end
  end

  assign sts.out_full = out_tvalid;

endmodule
`default_nettype wire

[hdl/geyer_saturation_intensity_unit.sv]
// Top level of the saturation point process intensity unit: register file and wiring.
// Depends on gsi_pkg, gsi_ctrl and gsi_dp.
//
//   Port group  Direction  Carries
//   in_*        stream in  one evaluate or commit proposal per transfer
//   out_*       stream out one result per transfer
//   cfg_*       APB slave  seven interaction registers at byte address 8*i
//
// Between an item's transfer in and the next ready, the walk reads each stored point,
// one per cycle, from the point memory, and the closeness pipeline then drains.
// Rejected items (bad kind, bad index, full store) skip the walk and go to the result.
// Reset clears the point count and presets the interaction registers;
// the point memory needs no clearing.
// A waiting result does not block the next transfer in; it stalls only the next result.
`default_nettype none
module geyer_saturation_intensity_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // point_index[9:0], new_x[25:10], new_y[41:26], zero fill
  input  wire logic [47:0]                  in_tdata,
  // command[0], kind[2:1]
  input  wire logic [2:0]                   in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // neighbours[10:0], log_weight[30:11], log_intensity[65:31], intensity_zero[66]
  output logic [71:0]                       out_tdata,
  // status[1:0]
  output logic [1:0]                        out_tuser,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [gsi_pkg::PADDR_W-1:0]  cfg_paddr,
  input  wire logic [gsi_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [gsi_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import gsi_pkg::*;

  cfg_t cfg_r;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_gamma  <= '0;
      cfg_r.radius_sq  <= '0;
      cfg_r.saturation <= Q_W'(ONE_Q);
      cfg_r.hard_core  <= 1'b0;
      cfg_r.periodic   <= 1'b0;
      cfg_r.period_x   <= '0;
      cfg_r.period_y   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (reg_idx)
        REG_LOG_GAMMA:  cfg_r.log_gamma  <= cfg_pwdata[LG_W-1:0];
        REG_RADIUS_SQ:  cfg_r.radius_sq  <= cfg_pwdata[RSQ_W-1:0];
        REG_SATURATION: cfg_r.saturation <= cfg_pwdata[Q_W-1:0];
        REG_HARD_CORE:  cfg_r.hard_core  <= cfg_pwdata[0];
        REG_PERIODIC:   cfg_r.periodic   <= cfg_pwdata[0];
        REG_PERIOD_X:   cfg_r.period_x   <= cfg_pwdata[COORD_W-1:0];
        REG_PERIOD_Y:   cfg_r.period_y   <= cfg_pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOG_GAMMA:  cfg_prdata = PDATA_W'(unsigned'(cfg_r.log_gamma));
      REG_RADIUS_SQ:  cfg_prdata = PDATA_W'(cfg_r.radius_sq);
      REG_SATURATION: cfg_prdata = PDATA_W'(cfg_r.saturation);
      REG_HARD_CORE:  cfg_prdata = PDATA_W'(cfg_r.hard_core);
      REG_PERIODIC:   cfg_prdata = PDATA_W'(cfg_r.periodic);
      REG_PERIOD_X:   cfg_prdata = PDATA_W'(cfg_r.period_x);
      REG_PERIOD_Y:   cfg_prdata = PDATA_W'(cfg_r.period_y);
      default:        cfg_prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  gsi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser[0]),
    .in_kind    (in_tuser[2:1]),
    .in_index   (in_tdata[9:0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  logic [CNT_W-1:0]       o_nb;
  logic [W_W-1:0]         o_w;
  logic signed [LI_W-1:0] o_li;
  logic                   o_iz;
  status_t                o_st;

  gsi_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_tuser[0]),
    .in_kind            (in_tuser[2:1]),
    .in_index           (in_tdata[9:0]),
    .in_x               (in_tdata[25:10]),
    .in_y               (in_tdata[41:26]),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_neighbours     (o_nb),
    .out_log_weight     (o_w),
    .out_log_intensity  (o_li),
    .out_intensity_zero (o_iz),
    .out_status         (o_st)
  );

  assign out_tdata = {5'b0, o_iz, o_li, o_w, o_nb};
  assign out_tuser = o_st;

endmodule
`default_nettype wire
